FILE: rtl/rlcp_pkg.sv
// ----------------------------------------------------------------------------
// rlcp_pkg
// Shared types, key table and divide-by-255 helper for the LED command parser.
// ----------------------------------------------------------------------------
package rlcp_pkg;

  localparam int NKEYS      = 5;
  localparam int KEY_MAX    = 5;
  localparam int PROG_W     = 3;

  // key order: on, r, g, b, bri
  localparam int KEY_ON     = 0;
  localparam int KEY_RED    = 1;
  localparam int KEY_GREEN  = 2;
  localparam int KEY_BLUE   = 3;
  localparam int KEY_BRI    = 4;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_NUL   = 8'h00;

  localparam logic [7:0] VAL_MAX  = 8'd255;
  localparam logic [6:0] DUTY_MAX = 7'd100;

  // One finished message: parsed values and which of them were present.
  typedef struct packed {
    logic [NKEYS-1:0]      valid;
    logic [NKEYS-1:0][7:0] value;
  } rlcp_rec_t;

  function automatic logic [PROG_W-1:0] key_len(input int k);
    logic [PROG_W-1:0] len;
    case (k)
      KEY_ON:  len = 3'd4;
      KEY_BRI: len = 3'd5;
      default: len = 3'd3;
    endcase
    return len;
  endfunction

  function automatic logic [7:0] key_char(input int k, input logic [PROG_W-1:0] idx);
    logic [7:0] ch;
    ch = CH_QUOTE;
    if (idx == 3'd1) begin
      case (k)
        KEY_ON:    ch = 8'h6F;  // o
        KEY_RED:   ch = 8'h72;  // r
        KEY_GREEN: ch = 8'h67;  // g
        default:   ch = 8'h62;  // b
      endcase
    end else if (idx == 3'd2) begin
      case (k)
        KEY_ON:  ch = 8'h6E;    // n
        KEY_BRI: ch = 8'h72;    // r
        default: ch = CH_QUOTE;
      endcase
    end else if (idx == 3'd3) begin
      ch = (k == KEY_BRI) ? 8'h69 : CH_QUOTE;  // i
    end
    return ch;
  endfunction

  // floor(x / 255), exact for x < 65280
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [15:0] t;
    t = x + {8'd0, x[15:8]} + 16'd1;
    return t[15:8];
  endfunction

endpackage

FILE: rtl/rgb_led_command_parser_unit.sv
// ----------------------------------------------------------------------------
// rgb_led_command_parser_unit
// Scans command messages byte by byte and reports LED settings and duties.
// ----------------------------------------------------------------------------
// Usage:
//   in channel  : one message character per beat (in_byte) with in_last_byte
//                 marking the final character. Bytes are taken one per cycle;
//                 in_stall rises only while two finished messages wait for
//                 the executor.
//   out channel : one beat per message, issued after its last byte: kept
//                 on/red/green/blue/brightness values and three duties.
//   cfg port    : cfg_wr_en writes cfg_wr_data into the invert-duty bit.
//   Path        : the last byte pushes the record into the queue; the
//                 executor pops it, runs MUL, SCALE and DUTY on the shared
//                 multiplier per colour, then loads the output register.
//   Throughput  : one byte per cycle while in_stall is low. The duty
//                 multiplier sets the message rate.
//   Reset       : synchronous, active low; settings go to off with all
//                 levels at 255, scan state clears, queue empties.
//   Stall       : out_stall holds the output beat; the executor finishes the
//                 next message and waits, the queue fills, then in_stall.
// ----------------------------------------------------------------------------
module rgb_led_command_parser_unit (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic       cfg_wr_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_last_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_power_value,
  output logic [7:0] out_red_value,
  output logic [7:0] out_green_value,
  output logic [7:0] out_blue_value,
  output logic [7:0] out_bright_value,
  output logic [6:0] out_red_duty,
  output logic [6:0] out_green_duty,
  output logic [6:0] out_blue_duty
);

  logic                invert_r, invert_nxt;
  logic                q_full, q_push, q_pop, q_valid;
  rlcp_pkg::rlcp_rec_t push_rec, pop_rec;

  // invert bit: write only while the block is idle
  assign invert_nxt = cfg_wr_en ? cfg_wr_data : invert_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      invert_r <= 1'b0;
    end else begin
      invert_r <= invert_nxt;
    end
  end

  // front: key matching on every accepted beat
  rlcp_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_byte      (in_byte),
    .in_last_byte (in_last_byte),
    .in_stall     (in_stall),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_rec        (push_rec)
  );

  // hold finished messages so scanning and scaling stall apart
  rlcp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_rec  (push_rec),
    .full      (q_full),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_rec   (pop_rec)
  );

  // back: apply settings, compute duties, drive the result beat
  rlcp_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .invert_duty      (invert_r),
    .q_valid          (q_valid),
    .q_rec            (pop_rec),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_power_value  (out_power_value),
    .out_red_value    (out_red_value),
    .out_green_value  (out_green_value),
    .out_blue_value   (out_blue_value),
    .out_bright_value (out_bright_value),
    .out_red_duty     (out_red_duty),
    .out_green_duty   (out_green_duty),
    .out_blue_duty    (out_blue_duty)
  );

endmodule

FILE: rtl/rlcp_front.sv
// ----------------------------------------------------------------------------
// rlcp_front
// Byte scanner: five key matchers in parallel, pending values per key.
// ----------------------------------------------------------------------------
module rlcp_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [7:0]        in_byte,
  input  logic              in_last_byte,
  output logic              in_stall,
  input  logic              q_full,
  output logic              q_push,
  output rlcp_pkg::rlcp_rec_t q_rec
);

  typedef enum logic [3:0] {
    PH_SEARCH = 4'b0001,
    PH_SKIP   = 4'b0010,
    PH_READ   = 4'b0100,
    PH_DONE   = 4'b1000
  } rlcp_phase_t;

  logic [rlcp_pkg::PROG_W-1:0] prog_r   [rlcp_pkg::NKEYS];
  logic [rlcp_pkg::PROG_W-1:0] prog_nxt [rlcp_pkg::NKEYS];
  logic [rlcp_pkg::PROG_W-1:0] prog_stp [rlcp_pkg::NKEYS];
  rlcp_phase_t                 phase_r   [rlcp_pkg::NKEYS];
  rlcp_phase_t                 phase_nxt [rlcp_pkg::NKEYS];
  rlcp_phase_t                 phase_stp [rlcp_pkg::NKEYS];
  logic [rlcp_pkg::NKEYS-1:0][7:0] pend_r, pend_nxt, pend_stp;
  logic [rlcp_pkg::NKEYS-1:0]      pvld_r, pvld_nxt, pvld_stp;
  logic                        ended_r, ended_nxt, ended_stp;
  logic                        accept;
  logic                        is_digit, is_sep;
  logic [3:0]                  digit;
  logic [11:0]                 acc [rlcp_pkg::NKEYS];

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign q_push   = accept && in_last_byte;
  assign is_digit = (in_byte >= rlcp_pkg::CH_ZERO) && (in_byte <= rlcp_pkg::CH_NINE);
  assign is_sep   = (in_byte == rlcp_pkg::CH_QUOTE) || (in_byte == rlcp_pkg::CH_COLON) ||
                    (in_byte == rlcp_pkg::CH_SPACE);
  assign digit    = 4'(in_byte - rlcp_pkg::CH_ZERO);

  always_comb begin
    ended_stp = ended_r;
    pend_stp  = pend_r;
    pvld_stp  = pvld_r;
    for (int k = 0; k < rlcp_pkg::NKEYS; k++) begin
      prog_stp[k]  = prog_r[k];
      phase_stp[k] = phase_r[k];
      acc[k] = {1'b0, pend_r[k], 3'd0} + {3'd0, pend_r[k], 1'b0} + {8'd0, digit};
    end
    if (!ended_r) begin
      if (in_byte == rlcp_pkg::CH_NUL) begin
        ended_stp = 1'b1;
      end else begin
        for (int k = 0; k < rlcp_pkg::NKEYS; k++) begin
          unique case (phase_r[k])
            PH_SEARCH: begin
              if (prog_r[k] < rlcp_pkg::key_len(k) &&
                  in_byte == rlcp_pkg::key_char(k, prog_r[k])) begin
                if (prog_r[k] + 3'd1 >= rlcp_pkg::key_len(k)) begin
                  phase_stp[k] = PH_SKIP;
                  prog_stp[k]  = '0;
                end else begin
                  prog_stp[k] = prog_r[k] + 3'd1;
                end
              end else begin
                prog_stp[k] = (in_byte == rlcp_pkg::CH_QUOTE) ? 3'd1 : 3'd0;
              end
            end
            PH_SKIP: begin
              if (!is_sep) begin
                if (is_digit) begin
                  pend_stp[k]  = {4'd0, digit};
                  pvld_stp[k]  = 1'b1;
                  phase_stp[k] = PH_READ;
                end else begin
                  phase_stp[k] = PH_DONE;
                end
              end
            end
            PH_READ: begin
              if (is_digit) begin
                pend_stp[k] = (acc[k] > 12'd255) ? rlcp_pkg::VAL_MAX : acc[k][7:0];
              end else begin
                phase_stp[k] = PH_DONE;
              end
            end
            PH_DONE: begin
            end
            default: begin
              phase_stp[k] = PH_DONE;
            end
          endcase
        end
      end
    end
  end

  // on an accepted beat clear everything at message end, otherwise take the stepped state
  always_comb begin
    q_rec.value = pend_stp;
    q_rec.valid = pvld_stp;
    ended_nxt = ended_r;
    pend_nxt  = pend_r;
    pvld_nxt  = pvld_r;
    for (int k = 0; k < rlcp_pkg::NKEYS; k++) begin
      prog_nxt[k]  = prog_r[k];
      phase_nxt[k] = phase_r[k];
    end
    if (accept) begin
      if (in_last_byte) begin
        ended_nxt = 1'b0;
        pend_nxt  = '0;
        pvld_nxt  = '0;
        for (int k = 0; k < rlcp_pkg::NKEYS; k++) begin
          prog_nxt[k]  = '0;
          phase_nxt[k] = PH_SEARCH;
        end
      end else begin
        ended_nxt = ended_stp;
        pend_nxt  = pend_stp;
        pvld_nxt  = pvld_stp;
        for (int k = 0; k < rlcp_pkg::NKEYS; k++) begin
          prog_nxt[k]  = prog_stp[k];
          phase_nxt[k] = phase_stp[k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ended_r <= 1'b0;
      pend_r  <= '0;
      pvld_r  <= '0;
      for (int k = 0; k < rlcp_pkg::NKEYS; k++) begin
        prog_r[k]  <= '0;
        phase_r[k] <= PH_SEARCH;
      end
    end else begin
      ended_r <= ended_nxt;
      pend_r  <= pend_nxt;
      pvld_r  <= pvld_nxt;
      for (int k = 0; k < rlcp_pkg::NKEYS; k++) begin
        prog_r[k]  <= prog_nxt[k];
        phase_r[k] <= phase_nxt[k];
      end
    end
  end

  // the on key, while still searching, never carries a pending value
  assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r[rlcp_pkg::KEY_ON] == PH_SEARCH) |-> !pvld_r[rlcp_pkg::KEY_ON])
    else $error("pending value on a key that was never matched");

  // message end clears the scan state
  assert property (@(posedge clk) disable iff (!rst_n)
    q_push |=> (ended_r == 1'b0) && (pvld_r == '0))
    else $error("scan state not cleared at message end");

  // a zero byte ends the scan
  assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !in_last_byte && in_byte == rlcp_pkg::CH_NUL) |=> ended_r)
    else $error("zero byte did not end the scan");

endmodule

FILE: rtl/rlcp_queue.sv
// ----------------------------------------------------------------------------
// rlcp_queue
// Two-entry queue of finished message records between scanner and executor.
// ----------------------------------------------------------------------------
module rlcp_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  rlcp_pkg::rlcp_rec_t push_rec,
  output logic                full,
  input  logic                pop,
  output logic                pop_valid,
  output rlcp_pkg::rlcp_rec_t pop_rec
);

  rlcp_pkg::rlcp_rec_t mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       do_pop;

  assign full      = (count_r == 2'd2);
  assign pop_valid = (count_r != 2'd0);
  assign pop_rec   = mem_r[rd_ptr_r];
  assign do_pop    = pop && pop_valid;

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) !(push && full))
    else $error("record pushed into a full queue");

  assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == 2'd0) |-> (wr_ptr_r == rd_ptr_r))
    else $error("queue pointers out of step");

  assert property (@(posedge clk) disable iff (!rst_n) count_r != 2'd3)
    else $error("queue count overflow");

endmodule

FILE: rtl/rlcp_back.sv
// ----------------------------------------------------------------------------
// rlcp_back
// Executor: applies a message record to the kept settings and works out the
// three duties with one shared multiplier.
// ----------------------------------------------------------------------------
module rlcp_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                invert_duty,
  input  logic                q_valid,
  input  rlcp_pkg::rlcp_rec_t q_rec,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [7:0]          out_power_value,
  output logic [7:0]          out_red_value,
  output logic [7:0]          out_green_value,
  output logic [7:0]          out_blue_value,
  output logic [7:0]          out_bright_value,
  output logic [6:0]          out_red_duty,
  output logic [6:0]          out_green_duty,
  output logic [6:0]          out_blue_duty
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_MUL   = 5'b00010,
    ST_SCALE = 5'b00100,
    ST_DUTY  = 5'b01000,
    ST_HOLD  = 5'b10000
  } rlcp_bstate_t;

  localparam logic [1:0] COL_LAST = 2'd2;

  rlcp_bstate_t state_r, state_nxt;
  logic [rlcp_pkg::NKEYS-1:0][7:0] set_r, set_nxt;
  logic [1:0]  col_r, col_nxt;
  logic [15:0] prod_r, prod_nxt;
  logic [14:0] hund_r, hund_nxt;
  logic [2:0][6:0] duty_r, duty_nxt;
  logic [7:0]  colour;
  logic [7:0]  duty_q;
  logic [6:0]  duty_raw, duty_fin;
  logic        load_out;
  logic        out_valid_r, out_valid_nxt;
  logic [rlcp_pkg::NKEYS-1:0][7:0] oval_r;
  logic [2:0][6:0] oduty_r;

  assign q_pop    = (state_r == ST_IDLE) && q_valid;
  assign load_out = (state_r == ST_HOLD) && (!out_valid_r || !out_stall);

  always_comb begin
    case (col_r)
      2'd0:    colour = set_r[rlcp_pkg::KEY_RED];
      2'd1:    colour = set_r[rlcp_pkg::KEY_GREEN];
      default: colour = set_r[rlcp_pkg::KEY_BLUE];
    endcase
    duty_q   = rlcp_pkg::div255({1'b0, hund_r});
    duty_raw = (set_r[rlcp_pkg::KEY_ON] == 8'd0) ? 7'd0 : duty_q[6:0];
    duty_fin = invert_duty ? (rlcp_pkg::DUTY_MAX - duty_raw) : duty_raw;
  end

  always_comb begin
    state_nxt     = state_r;
    set_nxt       = set_r;
    col_nxt       = col_r;
    prod_nxt      = prod_r;
    hund_nxt      = hund_r;
    duty_nxt      = duty_r;
    out_valid_nxt = out_valid_r && out_stall;
    unique case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          for (int k = 0; k < rlcp_pkg::NKEYS; k++) begin
            if (q_rec.valid[k]) begin
              set_nxt[k] = q_rec.value[k];
            end
          end
          col_nxt   = '0;
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        prod_nxt  = {8'd0, colour} * {8'd0, set_r[rlcp_pkg::KEY_BRI]};
        state_nxt = ST_SCALE;
      end
      ST_SCALE: begin
        hund_nxt  = {7'd0, rlcp_pkg::div255(prod_r)} * 15'd100;
        state_nxt = ST_DUTY;
      end
      ST_DUTY: begin
        duty_nxt[col_r] = duty_fin;
        if (col_r == COL_LAST) begin
          state_nxt = ST_HOLD;
        end else begin
          col_nxt   = col_r + 2'd1;
          state_nxt = ST_MUL;
        end
      end
      ST_HOLD: begin
        if (load_out) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      col_r       <= '0;
      set_r[rlcp_pkg::KEY_ON]    <= 8'd0;
      set_r[rlcp_pkg::KEY_RED]   <= rlcp_pkg::VAL_MAX;
      set_r[rlcp_pkg::KEY_GREEN] <= rlcp_pkg::VAL_MAX;
      set_r[rlcp_pkg::KEY_BLUE]  <= rlcp_pkg::VAL_MAX;
      set_r[rlcp_pkg::KEY_BRI]   <= rlcp_pkg::VAL_MAX;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      col_r       <= col_nxt;
      set_r       <= set_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    hund_r <= hund_nxt;
    duty_r <= duty_nxt;
    if (load_out) begin
      oval_r  <= set_r;
      oduty_r <= duty_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_power_value  = oval_r[rlcp_pkg::KEY_ON];
  assign out_red_value    = oval_r[rlcp_pkg::KEY_RED];
  assign out_green_value  = oval_r[rlcp_pkg::KEY_GREEN];
  assign out_blue_value   = oval_r[rlcp_pkg::KEY_BLUE];
  assign out_bright_value = oval_r[rlcp_pkg::KEY_BRI];
  assign out_red_duty     = oduty_r[0];
  assign out_green_duty   = oduty_r[1];
  assign out_blue_duty    = oduty_r[2];

  assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> (state_r == ST_MUL) && (col_r == 2'd0))
    else $error("popped record did not start the duty pass");

  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DUTY && col_r == COL_LAST) |=> (state_r == ST_HOLD))
    else $error("duty pass did not finish after the third colour");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (oduty_r[0] <= rlcp_pkg::DUTY_MAX) && (oduty_r[1] <= rlcp_pkg::DUTY_MAX) &&
                    (oduty_r[2] <= rlcp_pkg::DUTY_MAX))
    else $error("duty above one hundred percent");

endmodule

FILE: bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for rgb_led_command_parser_unit. A short table of
// hand-written messages runs first, then random JSON-style commands mixed
// with byte noise under three idle/stall mixes and both duty polarities.
// Every report beat is checked against a typed report or an in-bench model.
// ----------------------------------------------------------------------------
module tb;

  localparam int CYCLE_LIMIT = 500000;
  localparam int MAX_SHOWN   = 10;
  localparam int SETTLE      = 16;   // cycles to let the duty pipeline drain
  localparam int SEG_ITEMS   = 300;  // scanned bytes per random segment

  typedef enum logic [1:0] {SEEK_KEY, SKIP_SEP, READ_NUM, SPENT} key_phase_t;

  // one report beat, field for field as on the out_ ports
  typedef struct packed {
    logic [7:0] power;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] bright;
    logic [6:0] red_duty;
    logic [6:0] green_duty;
    logic [6:0] blue_duty;
  } led_report_t;

  localparam led_report_t NO_WANT = '0;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_wr_en = 1'b0;
  logic       cfg_wr_data = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_byte = 8'h00;
  logic       in_last_byte = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_power_value, out_red_value, out_green_value;
  logic [7:0] out_blue_value, out_bright_value;
  logic [6:0] out_red_duty, out_green_duty, out_blue_duty;

  rgb_led_command_parser_unit DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_byte          (in_byte),
    .in_last_byte     (in_last_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_power_value  (out_power_value),
    .out_red_value    (out_red_value),
    .out_green_value  (out_green_value),
    .out_blue_value   (out_blue_value),
    .out_bright_value (out_bright_value),
    .out_red_duty     (out_red_duty),
    .out_green_duty   (out_green_duty),
    .out_blue_duty    (out_blue_duty)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Parser model: kept settings, per-key scan state, duty polarity
  // --------------------------------------------------------------------------
  string       key_word [rlcp_pkg::NKEYS] = '{"\"on\"", "\"r\"", "\"g\"", "\"b\"", "\"bri\""};
  logic [7:0]  setting  [rlcp_pkg::NKEYS];
  logic [2:0]  match_pos[rlcp_pkg::NKEYS];
  key_phase_t  phase    [rlcp_pkg::NKEYS];
  logic [7:0]  pend_val [rlcp_pkg::NKEYS];
  bit          pend_ok  [rlcp_pkg::NKEYS];
  bit          scan_over;
  bit          invert_on;

  led_report_t reports_due[$];   // reports owed by the block, oldest first
  int          errors;
  int          src_idle_pct;
  int          sink_stall_pct;
  int          cycle_count;
  logic [7:0]  msg_bytes[$];     // message under construction
  string       noise_chars = "\"onrgbi: 0123456789,{}";

  function automatic void clear_scan();
    for (int k = 0; k < rlcp_pkg::NKEYS; k++) begin
      match_pos[k] = '0;
      phase[k]     = SEEK_KEY;
      pend_val[k]  = '0;
      pend_ok[k]   = 1'b0;
    end
    scan_over = 1'b0;
  endfunction

  // advance one key matcher by one character
  function automatic void scan_key(int k, logic [7:0] c);
    int p;
    int v;
    p = match_pos[k];
    case (phase[k])
      SEEK_KEY: begin
        if (p < key_word[k].len() && c == key_word[k][p]) begin
          p++;
          if (p >= key_word[k].len()) begin
            phase[k] = SKIP_SEP;
            p = 0;
          end
        end else begin
          // a stray quote may open the key again
          p = (c == "\"") ? 1 : 0;
        end
        match_pos[k] = p[2:0];
      end
      SKIP_SEP: begin
        if (c == "\"" || c == ":" || c == " ") begin
          // hold: separators are skipped
        end else if (c >= "0" && c <= "9") begin
          pend_val[k] = c - 8'h30;
          pend_ok[k]  = 1'b1;
          phase[k]    = READ_NUM;
        end else begin
          phase[k] = SPENT;
        end
      end
      READ_NUM: begin
        if (c >= "0" && c <= "9") begin
          v = int'(pend_val[k]) * 10 + int'(c) - 48;
          pend_val[k] = (v > 255) ? 8'd255 : v[7:0];
        end else begin
          phase[k] = SPENT;
        end
      end
      default: ;
    endcase
  endfunction

  function automatic logic [6:0] duty_pct(logic [7:0] colour);
    int d;
    d = 0;
    if (setting[rlcp_pkg::KEY_ON] != 8'd0)
      d = ((int'(colour) * int'(setting[rlcp_pkg::KEY_BRI])) / 255) * 100 / 255;
    if (invert_on)
      d = 100 - d;
    return d[6:0];
  endfunction

  // take one accepted input beat; on the last byte owe a report
  function automatic void parse_beat(logic [7:0] c, bit last, bit fixed, led_report_t want);
    led_report_t r;
    if (!scan_over) begin
      if (c == 8'h00)
        scan_over = 1'b1;
      else
        for (int k = 0; k < rlcp_pkg::NKEYS; k++) scan_key(k, c);
    end
    if (last) begin
      for (int k = 0; k < rlcp_pkg::NKEYS; k++)
        if (pend_ok[k]) setting[k] = pend_val[k];
      r.power      = setting[rlcp_pkg::KEY_ON];
      r.red        = setting[rlcp_pkg::KEY_RED];
      r.green      = setting[rlcp_pkg::KEY_GREEN];
      r.blue       = setting[rlcp_pkg::KEY_BLUE];
      r.bright     = setting[rlcp_pkg::KEY_BRI];
      r.red_duty   = duty_pct(setting[rlcp_pkg::KEY_RED]);
      r.green_duty = duty_pct(setting[rlcp_pkg::KEY_GREEN]);
      r.blue_duty  = duty_pct(setting[rlcp_pkg::KEY_BLUE]);
      // typed-in rows replace the model's answer
      reports_due.push_back(fixed ? want : r);
      clear_scan();
    end
  endfunction

  function automatic string report_text(led_report_t r);
    return $sformatf("on=%0d r=%0d g=%0d b=%0d bri=%0d duty=%0d/%0d/%0d", r.power, r.red,
                     r.green, r.blue, r.bright, r.red_duty, r.green_duty, r.blue_duty);
  endfunction

  // --------------------------------------------------------------------------
  // Input side: drive at the falling edge, hold the beat until accepted
  // --------------------------------------------------------------------------
  task automatic send_beat(logic [7:0] c, bit last, bit fixed, led_report_t want);
    @(negedge clk);
    // random idle cycles ahead of the beat
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_byte      <= c;
    in_last_byte <= last;
    do @(posedge clk); while (in_stall);
    parse_beat(c, last, fixed, want);
  endtask

  // write the duty polarity only with the block idle and every report home
  task automatic set_invert(bit v);
    @(negedge clk);
    in_valid <= 1'b0;
    while (reports_due.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    invert_on = v;
  endtask

  task automatic add_text(string s);
    for (int i = 0; i < s.len(); i++) msg_bytes.push_back(s[i]);
  endtask

  // random message: mostly well-formed commands, some raw noise
  task automatic build_message();
    int nkeys;
    int k;
    int pick;
    msg_bytes.delete();
    if ($urandom_range(0, 99) < 20) begin
      repeat ($urandom_range(1, 10)) begin
        if ($urandom_range(0, 1))
          msg_bytes.push_back(8'($urandom_range(0, 255)));
        else
          msg_bytes.push_back(noise_chars[$urandom_range(0, noise_chars.len() - 1)]);
      end
    end else begin
      add_text("{");
      nkeys = $urandom_range(1, 6);
      for (int j = 0; j < nkeys; j++) begin
        k = $urandom_range(0, rlcp_pkg::NKEYS - 1);
        add_text(key_word[k]);
        case ($urandom_range(0, 4))
          0: add_text(":");
          1: add_text(": ");
          2: add_text(" : ");
          3: add_text("\": ");
          default: ;
        endcase
        pick = $urandom_range(0, 99);
        if (pick < 55)
          add_text($sformatf("%0d", $urandom_range(0, 255)));
        else if (pick < 65)
          add_text("0");
        else if (pick < 85)
          // long digit runs, leading zeros and overflow
          repeat ($urandom_range(1, 6)) msg_bytes.push_back(8'(48 + $urandom_range(0, 9)));
        else if (pick < 95)
          add_text("true");
        // else: no value at all
        if ($urandom_range(0, 99) < 6)
          msg_bytes.push_back(8'h00);
        else if ($urandom_range(0, 99) < 4)
          msg_bytes.push_back(8'($urandom_range(1, 255)));
        if (j < nkeys - 1)
          add_text($urandom_range(0, 1) ? ", " : ",");
      end
      // now and then end the message right on the value
      if ($urandom_range(0, 3) != 0)
        add_text("}");
    end
  endtask

  // --------------------------------------------------------------------------
  // Output side: random stall, check every accepted report beat
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < sink_stall_pct);
  end

  always @(posedge clk) begin
    led_report_t got;
    led_report_t want;
    string       bad;
    if (rst_n && out_valid && !out_stall) begin
      got = '{out_power_value, out_red_value, out_green_value, out_blue_value,
              out_bright_value, out_red_duty, out_green_duty, out_blue_duty};
      if (reports_due.size() == 0) begin
        errors++;
        if (errors <= MAX_SHOWN)
          $display("%0t: report beat with none owed: %s", $time, report_text(got));
      end else begin
        want = reports_due.pop_front();
        bad = "";
        if (got.power !== want.power)           bad = {bad, " power"};
        if (got.red !== want.red)               bad = {bad, " red"};
        if (got.green !== want.green)           bad = {bad, " green"};
        if (got.blue !== want.blue)             bad = {bad, " blue"};
        if (got.bright !== want.bright)         bad = {bad, " bright"};
        if (got.red_duty !== want.red_duty)     bad = {bad, " red_duty"};
        if (got.green_duty !== want.green_duty) bad = {bad, " green_duty"};
        if (got.blue_duty !== want.blue_duty)   bad = {bad, " blue_duty"};
        if (bad != "") begin
          errors++;
          if (errors <= MAX_SHOWN)
            $display("%0t: report mismatch in%s\n  expected %s\n  actual   %s",
                     $time, bad, report_text(want), report_text(got));
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Directed table. '#' stands for byte 0xFF and '@' for the zero byte.
  // Rows with a typed report are checked against it, the rest against the
  // model.
  // --------------------------------------------------------------------------
  string step_text[7] = '{
    "#",                  // one-byte message right after reset: defaults
    "\"on\"999",          // power on, value saturates at 255
    "\"r\"0",             // colour at zero
    "\"g\"7@9",           // zero byte ends the scan, 7 is kept
    "\"b\"a\"b\"1",       // key without digits, later copy ignored
    "\"br\"b\"4",         // partial key, quote restarts the match
    "\"bri\"0"            // brightness zero: every duty drops to zero
  };
  bit step_fixed[7] = '{1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1};
  led_report_t step_want[7] = '{
    '{8'd0,   8'd255, 8'd255, 8'd255, 8'd255, 7'd0,   7'd0,   7'd0},
    '{8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 7'd100, 7'd100, 7'd100},
    '{8'd255, 8'd0,   8'd255, 8'd255, 8'd255, 7'd0,   7'd100, 7'd100},
    NO_WANT,
    NO_WANT,
    NO_WANT,
    '{8'd255, 8'd0,   8'd7,   8'd4,   8'd0,   7'd0,   7'd0,   7'd0}
  };

  initial begin
    logic [7:0] c;
    bit         seen_nul;
    int         live_items;

    errors         = 0;
    cycle_count    = 0;
    src_idle_pct   = 6;
    sink_stall_pct = 56;
    invert_on      = 1'b0;
    setting[rlcp_pkg::KEY_ON] = 8'd0;
    for (int k = rlcp_pkg::KEY_RED; k < rlcp_pkg::NKEYS; k++) setting[k] = 8'd255;
    clear_scan();

    // hold reset, then release it at a falling edge
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    set_invert(1'b0);

    // walk the directed table
    foreach (step_text[r]) begin
      for (int i = 0; i < step_text[r].len(); i++) begin
        case (step_text[r][i])
          "@":     c = 8'h00;
          "#":     c = 8'hFF;
          default: c = step_text[r][i];
        endcase
        send_beat(c, i == step_text[r].len() - 1, step_fixed[r], step_want[r]);
      end
    end

    // random part: sender-light/sink-heavy, then the reverse, then no idling;
    // flip the duty polarity at every segment boundary
    for (int seg = 0; seg < 6; seg++) begin
      src_idle_pct   = (seg < 2) ? 6 : (seg < 4) ? 56 : 0;
      sink_stall_pct = (seg < 2) ? 56 : (seg < 4) ? 6 : 0;
      set_invert(seg % 2 == 0);
      live_items = 0;
      while (live_items < SEG_ITEMS) begin
        build_message();
        seen_nul = 1'b0;
        foreach (msg_bytes[i]) begin
          // bytes past a zero byte are ignored; do not count them
          if (!seen_nul) live_items++;
          if (msg_bytes[i] == 8'h00) seen_nul = 1'b1;
          send_beat(msg_bytes[i], i == msg_bytes.size() - 1, 1'b0, NO_WANT);
        end
      end
    end

    // drop valid, drain the owed reports, then watch for strays
    @(negedge clk);
    in_valid <= 1'b0;
    while (reports_due.size() != 0) @(posedge clk);
    repeat (2 * SETTLE) @(posedge clk);

    if (errors == 0 && reports_due.size() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
